// File: sv/ssr_pkg.sv
`timescale 1ns / 1ps

package ssr_pkg;

    localparam int MAX_RUN     = 4;
    localparam int SAMPLE_BITS = 16;
    localparam int HALF_W      = SAMPLE_BITS + 1;
    localparam int THR_W       = 16;
    localparam int LIMIT_W     = 3;
    localparam int CELLS       = MAX_RUN + 1;
    localparam int CNT_W       = $clog2(MAX_RUN + 2);
    localparam int IDX_W       = $clog2(MAX_RUN + 1);
    localparam int CMP_W       = ((HALF_W > THR_W + 1) ? HALF_W : THR_W + 1) + 1;
    localparam int ADDR_W      = 3;
    localparam int DATA_W      = 32;

    localparam logic [THR_W-1:0]   THR_RESET   = THR_W'(500);
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(2);

    localparam logic REG_JUMP_THRESHOLD = 1'b0;
    localparam logic REG_RUN_LIMIT      = 1'b1;

    typedef logic [SAMPLE_BITS-1:0] sample_t;
    typedef logic [HALF_W-1:0]      half_t;
    typedef logic [HALF_W:0]        half_sum_t;
    typedef logic [THR_W-1:0]       thr_t;
    typedef logic [LIMIT_W-1:0]     limit_t;
    typedef logic [CNT_W-1:0]       cnt_t;
    typedef logic [IDX_W-1:0]       idx_t;
    typedef logic [CMP_W-1:0]       cmp_t;

    typedef enum logic [1:0] {
        RUN_NONE,
        RUN_UP,
        RUN_DOWN
    } run_mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DECIDE,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic shift;
        logic append;
        idx_t idx;
    } chain_ctl_t;

    function automatic cnt_t eff_limit(input limit_t lim);
        cnt_t res;
        if (int'(lim) > MAX_RUN)
        begin
            res = cnt_t'(MAX_RUN);
        end
        else
        begin
            res = cnt_t'(lim);
        end
        return res;
    endfunction

endpackage

// File: sv/ssr_cell.sv
`timescale 1ns / 1ps

module ssr_cell (
    input  logic                clk,
    input  ssr_pkg::chain_ctl_t ctl,
    input  logic                load,
    input  ssr_pkg::sample_t    sample,
    input  ssr_pkg::sample_t    right_value,
    output ssr_pkg::sample_t    value
);

    ssr_pkg::sample_t value_reg;
    ssr_pkg::sample_t value_next;

    always_comb
    begin
        value_next = value_reg;
        if (ctl.shift)
        begin
            value_next = right_value;
        end
        else if (ctl.append && load)
        begin
            value_next = sample;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

// File: sv/ssr_ctrl.sv
`timescale 1ns / 1ps

module ssr_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                sample_valid,
    output logic                sample_stall,
    input  ssr_pkg::sample_t    sample,
    input  logic                scan_end,
    input  ssr_pkg::thr_t       jump_threshold,
    input  ssr_pkg::limit_t     run_limit,
    input  ssr_pkg::sample_t    head,
    output ssr_pkg::chain_ctl_t chain_ctl,
    output logic                result_valid,
    input  logic                result_stall,
    output ssr_pkg::half_t      value_half,
    output logic                replaced,
    output logic                scan_done,
    output logic                batch_last,
    output ssr_pkg::sample_t    held_sample
);

    ssr_pkg::state_t    state_reg, state_next;
    ssr_pkg::run_mode_t run_mode_reg, run_mode_next;
    logic               have_prev_reg, have_prev_next;
    ssr_pkg::half_t     prev_reg, prev_next;
    ssr_pkg::half_t     base_reg, base_next;
    ssr_pkg::cnt_t      held_count_reg, held_count_next;
    ssr_pkg::cnt_t      mids_left_reg, mids_left_next;
    ssr_pkg::cnt_t      emit_left_reg, emit_left_next;
    logic               result_valid_reg, result_valid_next;

    ssr_pkg::sample_t   sample_reg, sample_next;
    logic               last_reg, last_next;
    ssr_pkg::half_t     mid_reg, mid_next;
    ssr_pkg::half_t     value_half_reg, value_half_next;
    logic               replaced_reg, replaced_next;
    logic               scan_done_reg, scan_done_next;
    logic               batch_last_reg, batch_last_next;

    logic               accept;
    logic               slot_free;
    logic               emit_go;

    ssr_pkg::half_t     cur;
    ssr_pkg::cmp_t      cur_x;
    ssr_pkg::cmp_t      prev_x;
    ssr_pkg::cmp_t      thr2_x;
    logic               up_jump;
    logic               down_jump;
    logic               closing;
    ssr_pkg::half_sum_t mid_sum;
    ssr_pkg::half_t     mid;
    ssr_pkg::cnt_t      limit_eff;
    ssr_pkg::cnt_t      count_after;
    logic               jump;
    logic               hold;

    assign cur       = {sample_reg, 1'b0};
    assign cur_x     = ssr_pkg::cmp_t'(cur);
    assign prev_x    = ssr_pkg::cmp_t'(prev_reg);
    assign thr2_x    = ssr_pkg::cmp_t'({jump_threshold, 1'b0});
    assign up_jump   = cur_x >= (prev_x + thr2_x);
    assign down_jump = prev_x >= (cur_x + thr2_x);
    assign closing   = ((run_mode_reg == ssr_pkg::RUN_UP) && down_jump)
                    || ((run_mode_reg == ssr_pkg::RUN_DOWN) && up_jump);
    assign mid_sum   = ssr_pkg::half_sum_t'(base_reg) + ssr_pkg::half_sum_t'(cur);
    assign mid       = mid_sum[ssr_pkg::HALF_W:1];
    assign limit_eff = ssr_pkg::eff_limit(run_limit);
    assign count_after = held_count_reg + ssr_pkg::cnt_t'(1);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ssr_pkg::ST_IDLE:
            begin
                if (sample_valid)
                begin
                    state_next = ssr_pkg::ST_EVAL;
                end
            end
            ssr_pkg::ST_EVAL:
            begin
                state_next = ssr_pkg::ST_DECIDE;
            end
            ssr_pkg::ST_DECIDE:
            begin
                if (emit_left_next != '0)
                begin
                    state_next = ssr_pkg::ST_EMIT;
                end
                else
                begin
                    state_next = ssr_pkg::ST_IDLE;
                end
            end
            ssr_pkg::ST_EMIT:
            begin
                if (emit_go && (emit_left_reg == ssr_pkg::cnt_t'(1)))
                begin
                    state_next = ssr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ssr_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        sample_stall     = state_reg != ssr_pkg::ST_IDLE;
        accept           = (state_reg == ssr_pkg::ST_IDLE) && sample_valid;
        slot_free        = !result_valid_reg || !result_stall;
        emit_go          = (state_reg == ssr_pkg::ST_EMIT) && slot_free;
        chain_ctl.shift  = emit_go;
        chain_ctl.append = state_reg == ssr_pkg::ST_DECIDE;
        chain_ctl.idx    = held_count_reg[ssr_pkg::IDX_W-1:0];
    end

    always_comb
    begin
        run_mode_next     = run_mode_reg;
        have_prev_next    = have_prev_reg;
        prev_next         = prev_reg;
        base_next         = base_reg;
        held_count_next   = held_count_reg;
        mids_left_next    = mids_left_reg;
        emit_left_next    = emit_left_reg;
        sample_next       = sample_reg;
        last_next         = last_reg;
        mid_next          = mid_reg;
        value_half_next   = value_half_reg;
        replaced_next     = replaced_reg;
        scan_done_next    = scan_done_reg;
        batch_last_next   = batch_last_reg;
        result_valid_next = result_valid_reg && result_stall;
        jump              = 1'b0;
        hold              = 1'b0;

        if (accept)
        begin
            sample_next = sample;
            last_next   = scan_end;
        end

        if (state_reg == ssr_pkg::ST_EVAL)
        begin
            mids_left_next = '0;
            if (closing)
            begin
                mid_next       = mid;
                prev_next      = mid;
                run_mode_next  = ssr_pkg::RUN_NONE;
                mids_left_next = held_count_reg;
            end
        end

        if (state_reg == ssr_pkg::ST_DECIDE)
        begin
            if (run_mode_reg == ssr_pkg::RUN_NONE)
            begin
                jump = have_prev_reg && (up_jump || down_jump);
                hold = jump && (limit_eff != '0);
                if (jump)
                begin
                    base_next = prev_reg;
                end
                if (hold)
                begin
                    run_mode_next = up_jump ? ssr_pkg::RUN_UP : ssr_pkg::RUN_DOWN;
                end
            end
            else
            begin
                hold = count_after <= limit_eff;
                if (!hold)
                begin
                    run_mode_next = ssr_pkg::RUN_NONE;
                end
            end
            prev_next      = cur;
            have_prev_next = 1'b1;
            if (last_reg)
            begin
                hold           = 1'b0;
                run_mode_next  = ssr_pkg::RUN_NONE;
                have_prev_next = 1'b0;
                prev_next      = '0;
                base_next      = '0;
            end
            held_count_next = count_after;
            emit_left_next  = hold ? mids_left_reg : count_after;
        end

        if (emit_go)
        begin
            result_valid_next = 1'b1;
            replaced_next     = mids_left_reg != '0;
            value_half_next   = (mids_left_reg != '0) ? mid_reg : {head, 1'b0};
            batch_last_next   = emit_left_reg == ssr_pkg::cnt_t'(1);
            scan_done_next    = (emit_left_reg == ssr_pkg::cnt_t'(1)) && last_reg;
            emit_left_next    = emit_left_reg - ssr_pkg::cnt_t'(1);
            held_count_next   = held_count_reg - ssr_pkg::cnt_t'(1);
            if (mids_left_reg != '0)
            begin
                mids_left_next = mids_left_reg - ssr_pkg::cnt_t'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ssr_pkg::ST_IDLE;
            run_mode_reg     <= ssr_pkg::RUN_NONE;
            have_prev_reg    <= 1'b0;
            prev_reg         <= '0;
            base_reg         <= '0;
            held_count_reg   <= '0;
            mids_left_reg    <= '0;
            emit_left_reg    <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            run_mode_reg     <= run_mode_next;
            have_prev_reg    <= have_prev_next;
            prev_reg         <= prev_next;
            base_reg         <= base_next;
            held_count_reg   <= held_count_next;
            mids_left_reg    <= mids_left_next;
            emit_left_reg    <= emit_left_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg     <= sample_next;
        last_reg       <= last_next;
        mid_reg        <= mid_next;
        value_half_reg <= value_half_next;
        replaced_reg   <= replaced_next;
        scan_done_reg  <= scan_done_next;
        batch_last_reg <= batch_last_next;
    end

    assign result_valid = result_valid_reg;
    assign value_half   = value_half_reg;
    assign replaced     = replaced_reg;
    assign scan_done    = scan_done_reg;
    assign batch_last   = batch_last_reg;
    assign held_sample  = sample_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        held_count_reg <= ssr_pkg::cnt_t'(ssr_pkg::CELLS))
        else $error("held sample count exceeds the cell chain");

    a_emit_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ssr_pkg::ST_EMIT) |-> (emit_left_reg != '0))
        else $error("emit state entered with no result pending");

    a_mids_within: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ssr_pkg::ST_EMIT) |-> (mids_left_reg <= emit_left_reg))
        else $error("more midpoint results pending than results");

    a_open_run_held: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ssr_pkg::ST_IDLE) && (run_mode_reg != ssr_pkg::RUN_NONE))
        |-> ((held_count_reg != '0) && have_prev_reg))
        else $error("open run without held samples");

    a_accept_eval: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ssr_pkg::ST_IDLE) && sample_valid) |=> (state_reg == ssr_pkg::ST_EVAL))
        else $error("accepted transaction not evaluated");

endmodule

// File: sv/scan_spike_run_removal_unit.sv
// Flow: an accepted transaction passes through the EVAL and DECIDE states and then
// EMIT, where each result is registered; an item releases n results (0 to 5).
// Results leave the held-sample cell chain one per cycle unless result_stall holds them.
// A new transaction is taken once the last result of the previous one is registered.
// Reset (rst_n, asynchronous, active low) restores threshold 500 and run limit 2 and
// clears the scan state; held sample values in the cell chain are not cleared.
`timescale 1ns / 1ps

module scan_spike_run_removal_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ssr_pkg::ADDR_W-1:0]     paddr,
    input  logic [ssr_pkg::DATA_W-1:0]     pwdata,
    output logic [ssr_pkg::DATA_W-1:0]     prdata,
    output logic                           pready,
    input  logic                           sample_valid,
    output logic                           sample_stall,
    input  logic [ssr_pkg::SAMPLE_BITS-1:0] sample,
    input  logic                           scan_end,
    output logic                           result_valid,
    input  logic                           result_stall,
    output logic [ssr_pkg::HALF_W-1:0]     value_half,
    output logic                           replaced,
    output logic                           scan_done,
    output logic                           batch_last
);

    ssr_pkg::thr_t       jump_threshold_reg, jump_threshold_next;
    ssr_pkg::limit_t     run_limit_reg, run_limit_next;
    logic                cfg_write;
    ssr_pkg::chain_ctl_t chain_ctl;
    ssr_pkg::sample_t    cell_value [ssr_pkg::CELLS];
    ssr_pkg::sample_t    sample_ctrl_value;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        jump_threshold_next = jump_threshold_reg;
        run_limit_next      = run_limit_reg;
        if (cfg_write)
        begin
            case (paddr[2])
                ssr_pkg::REG_JUMP_THRESHOLD:
                begin
                    jump_threshold_next = pwdata[ssr_pkg::THR_W-1:0];
                end
                ssr_pkg::REG_RUN_LIMIT:
                begin
                    run_limit_next = pwdata[ssr_pkg::LIMIT_W-1:0];
                end
                default:
                begin
                    jump_threshold_next = jump_threshold_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            ssr_pkg::REG_JUMP_THRESHOLD:
            begin
                prdata = ssr_pkg::DATA_W'(jump_threshold_reg);
            end
            ssr_pkg::REG_RUN_LIMIT:
            begin
                prdata = ssr_pkg::DATA_W'(run_limit_reg);
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            jump_threshold_reg <= ssr_pkg::THR_RESET;
            run_limit_reg      <= ssr_pkg::LIMIT_RESET;
        end
        else
        begin
            jump_threshold_reg <= jump_threshold_next;
            run_limit_reg      <= run_limit_next;
        end
    end

    // The chain holds the open run oldest first; a shift moves every sample one cell
    // toward the head, and an append writes the cell at the current fill position.
    for (genvar i = 0; i < ssr_pkg::CELLS; i++)
    begin : g_cell
        ssr_pkg::sample_t right_value;
        logic             load;

        if (i == ssr_pkg::CELLS - 1)
        begin : g_tail
            assign right_value = '0;
        end
        else
        begin : g_body
            assign right_value = cell_value[i+1];
        end

        assign load = chain_ctl.idx == ssr_pkg::idx_t'(i);

        ssr_cell u_cell (
            .clk         (clk),
            .ctl         (chain_ctl),
            .load        (load),
            .sample      (sample_ctrl_value),
            .right_value (right_value),
            .value       (cell_value[i])
        );
    end

    ssr_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .sample_valid   (sample_valid),
        .sample_stall   (sample_stall),
        .sample         (sample),
        .scan_end       (scan_end),
        .jump_threshold (jump_threshold_reg),
        .run_limit      (run_limit_reg),
        .head           (cell_value[0]),
        .chain_ctl      (chain_ctl),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .value_half     (value_half),
        .replaced       (replaced),
        .scan_done      (scan_done),
        .batch_last     (batch_last),
        .held_sample    (sample_ctrl_value)
    );

endmodule
